// File: rtl/assert_macros.svh
// Assertion macros for the modules that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and quiet while i_rst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and quiet while i_rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dipq_pkg.sv
// Types and constants shared by the deferred interrupt priority queue modules.
package dipq_pkg;

    // Default sizes and fixed widths.
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int SOURCE_BITS_DEF = 8;
    localparam int EVENT_BITS_DEF  = 4;
    localparam int MAX_RESULTS     = 32;
    localparam int PRI_W           = 4;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_ACCEPTED  = 3'd0,
        KIND_DUPLICATE = 3'd1,
        KIND_FULL      = 3'd2,
        KIND_DISPATCH  = 3'd3,
        KIND_NONE      = 3'd4
    } t_kind;

    // Input actions.
    localparam logic ACT_DEFER   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // One input word.
    typedef struct packed {
        logic       action;
        logic [7:0] source_id;
        logic [3:0] priority_req;
        logic [3:0] event_bits;
        logic [3:0] current_level;
    } t_in;

    // One result word.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_source;
        logic [3:0] out_priority;
        logic [3:0] out_events;
        logic [3:0] pending_level;
        logic       last;
    } t_out;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_INS_SHIFT,
        ST_INS_PUT,
        ST_REL_HEAD,
        ST_REL_POP
    } t_state;

endpackage

// File: rtl/deferred_interrupt_priority_queue.sv
// Top level of the deferred interrupt priority queue: memory, controller and result register.
//
// Usage: drive an input word on i_item and raise start; the word is taken at a rising
// edge where start is high and busy is low. busy stays high until the last result of
// that word has been issued. Each result word shows on o_result for exactly one cycle
// with o_strobe high; the receiver cannot stall it, so it must take every strobed word.
// The final result of an input word has last set.
// A defer word that is suppressed, dropped or taken into an empty queue gives its one
// result from ST_DECIDE; one that lands at the tail gives it from ST_INS_SHIFT.
// Each held entry of lower priority that must move toward the tail takes its own
// ST_INS_SHIFT step, and a defer that moves every held entry ends in ST_INS_PUT. A
// release word passes ST_DECIDE and ST_REL_HEAD and then gives one dispatched entry per
// cycle from ST_REL_POP, up to 32 entries; a release with nothing eligible gives one
// result from ST_DECIDE. The single read port of the entry memory sets this pace: one
// entry is read per cycle. Every result passes through the result register.
// Reset (synchronous, active low) empties the queue and clears the pending level and
// pending events; the entry memory itself needs no clearing.
module deferred_interrupt_priority_queue #(
    parameter int QUEUE_DEPTH = dipq_pkg::QUEUE_DEPTH_DEF,
    parameter int SOURCE_BITS = dipq_pkg::SOURCE_BITS_DEF,
    parameter int EVENT_BITS  = dipq_pkg::EVENT_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  dipq_pkg::t_in  i_item,
    output logic           o_strobe,
    output dipq_pkg::t_out o_result
);
    import dipq_pkg::*;

`include "assert_macros.svh"

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int ENW = SOURCE_BITS + PRI_W + EVENT_BITS;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [ENW-1:0] mem_wdata;
    logic [AW-1:0]  mem_raddr;
    logic [ENW-1:0] mem_rdata;
    logic           res_valid;
    t_out           res;
    logic           r_strobe;
    t_out           r_result;

    // Entry storage.
    dipq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Sequencer for inserts and releases.
    dipq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SOURCE_BITS (SOURCE_BITS),
        .EVENT_BITS  (EVENT_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_item      (i_item),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // Result register: the strobe is control, the word is payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= res;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // A taken word keeps the block busy in the next cycle.
    `ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "busy low after an accepted word")

    // Only dispatched entries may be followed by more results of the same word.
    `ASSERT_IMPL(a_single_last, o_strobe && (o_result.kind != KIND_DISPATCH), o_result.last, "non-dispatch result without last")

    // The final result of a word leaves the block ready for the next one.
    `ASSERT_IMPL(a_idle_at_last, o_strobe && o_result.last, !busy, "still busy at the last result")

    // The queue is sorted, so the new head never outranks the popped entry.
    `ASSERT_IMPL(a_sorted_pop, o_strobe && (o_result.kind == KIND_DISPATCH), o_result.pending_level <= o_result.out_priority, "pending level above dispatched priority")

endmodule

// File: rtl/dipq_ram.sv
// Entry memory: one write port, one read port, registered read data.
module dipq_ram #(
    parameter int DEPTH = dipq_pkg::QUEUE_DEPTH_DEF,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/dipq_ctrl.sv
// Queue controller: circular sorted buffer walk for inserts and head pops for releases.
module dipq_ctrl #(
    parameter int QUEUE_DEPTH = dipq_pkg::QUEUE_DEPTH_DEF,
    parameter int SOURCE_BITS = dipq_pkg::SOURCE_BITS_DEF,
    parameter int EVENT_BITS  = dipq_pkg::EVENT_BITS_DEF
) (
    input  logic                                                       i_clk,
    input  logic                                                       i_rst_n,
    input  logic                                                       i_start,
    output logic                                                       o_busy,
    input  dipq_pkg::t_in                                              i_item,
    output logic                                                       o_res_valid,
    output dipq_pkg::t_out                                             o_res,
    output logic                                                       o_mem_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0]                             o_mem_waddr,
    output logic [SOURCE_BITS+dipq_pkg::PRI_W+EVENT_BITS-1:0]          o_mem_wdata,
    output logic [$clog2(QUEUE_DEPTH)-1:0]                             o_mem_raddr,
    input  logic [SOURCE_BITS+dipq_pkg::PRI_W+EVENT_BITS-1:0]          i_mem_rdata
);
    import dipq_pkg::*;

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int NW  = $clog2(MAX_RESULTS);
    localparam int ENW = SOURCE_BITS + PRI_W + EVENT_BITS;

    t_state                r_state, n_state;
    t_in                   r_item, n_item;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_head, n_head;
    logic [PRI_W-1:0]      r_hp, n_hp;
    logic [EVENT_BITS-1:0] r_pe, n_pe;
    logic [AW-1:0]         r_j, n_j;
    logic [ENW-1:0]        r_cur, n_cur;
    logic [NW-1:0]         r_n, n_n;

    logic [SOURCE_BITS-1:0] it_src;
    logic [EVENT_BITS-1:0]  it_ev;
    logic [PRI_W-1:0]       it_pri;
    logic [PRI_W-1:0]       it_lvl;
    logic [ENW-1:0]         new_entry;
    logic [PRI_W-1:0]       rd_pri;
    logic [PRI_W-1:0]       hp_max;
    logic [SOURCE_BITS-1:0] cur_src;
    logic [PRI_W-1:0]       cur_pri;
    logic [EVENT_BITS-1:0]  cur_ev;
    logic [CW-1:0]          pop_count;
    logic [AW-1:0]          pop_head;
    logic [PRI_W-1:0]       pop_pri;
    logic                   pop_more;

    // Physical slot of a logical position counted from the head, wrapping at the depth.
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (AW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Fields of the held item and of the entries in flight.
    assign it_src    = SOURCE_BITS'(r_item.source_id);
    assign it_ev     = EVENT_BITS'(r_item.event_bits);
    assign it_pri    = r_item.priority_req;
    assign it_lvl    = r_item.current_level;
    assign new_entry = {it_src, it_pri, it_ev};
    assign rd_pri    = i_mem_rdata[EVENT_BITS +: PRI_W];
    assign hp_max    = (it_pri > r_hp) ? it_pri : r_hp;
    assign cur_src   = r_cur[PRI_W+EVENT_BITS +: SOURCE_BITS];
    assign cur_pri   = r_cur[EVENT_BITS +: PRI_W];
    assign cur_ev    = r_cur[EVENT_BITS-1:0];

    // What a pop of the head leaves behind; the read data is the entry after the head.
    assign pop_count = r_count - CW'(1);
    assign pop_head  = f_phys(r_head, AW'(1));
    assign pop_pri   = (pop_count == '0) ? '0 : rd_pri;
    assign pop_more  = (pop_count != '0) && (pop_pri > it_lvl) && (r_n != NW'(MAX_RESULTS - 1));

    assign o_busy = (r_state != ST_IDLE);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_hp    <= '0;
            r_pe    <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_hp    <= n_hp;
            r_pe    <= n_pe;
        end
    end

    // Payload and walk registers.
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_j    <= n_j;
        r_cur  <= n_cur;
        r_n    <= n_n;
    end

    // Next state, memory accesses and results.
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_count     = r_count;
        n_head      = r_head;
        n_hp        = r_hp;
        n_pe        = r_pe;
        n_j         = r_j;
        n_cur       = r_cur;
        n_n         = r_n;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_raddr = '0;
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_item  = i_item;
                    n_state = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                if (r_item.action == ACT_DEFER) begin
                    priority if ((r_pe & it_ev) != '0) begin
                        o_res_valid         = 1'b1;
                        o_res.kind          = KIND_DUPLICATE;
                        o_res.pending_level = r_hp;
                        o_res.last          = 1'b1;
                        n_state             = ST_IDLE;
                    end else if (r_count == CW'(QUEUE_DEPTH)) begin
                        o_res_valid         = 1'b1;
                        o_res.kind          = KIND_FULL;
                        o_res.pending_level = r_hp;
                        o_res.last          = 1'b1;
                        n_state             = ST_IDLE;
                    end else if (r_count == '0) begin
                        // Empty queue: the new entry becomes the head.
                        o_mem_we            = 1'b1;
                        o_mem_waddr         = r_head;
                        o_mem_wdata         = new_entry;
                        n_count             = r_count + CW'(1);
                        n_pe                = r_pe | it_ev;
                        n_hp                = hp_max;
                        o_res_valid         = 1'b1;
                        o_res.kind          = KIND_ACCEPTED;
                        o_res.pending_level = hp_max;
                        o_res.last          = 1'b1;
                        n_state             = ST_IDLE;
                    end else begin
                        // Start the walk at the tail entry.
                        n_j         = AW'(r_count - CW'(1));
                        o_mem_raddr = f_phys(r_head, AW'(r_count - CW'(1)));
                        n_state     = ST_INS_SHIFT;
                    end
                end else begin
                    if ((r_hp > it_lvl) && (r_count != '0)) begin
                        o_mem_raddr = r_head;
                        n_n         = '0;
                        n_state     = ST_REL_HEAD;
                    end else begin
                        if (r_hp > it_lvl) begin
                            n_hp = '0;
                        end
                        o_res_valid         = 1'b1;
                        o_res.kind          = KIND_NONE;
                        o_res.pending_level = (r_hp > it_lvl) ? '0 : r_hp;
                        o_res.last          = 1'b1;
                        n_state             = ST_IDLE;
                    end
                end
            end

            ST_INS_SHIFT: begin
                // The read data is the entry at logical position r_j.
                o_mem_we    = 1'b1;
                o_mem_waddr = f_phys(r_head, r_j + AW'(1));
                if (rd_pri < it_pri) begin
                    // Lower priority moves one slot toward the tail.
                    o_mem_wdata = i_mem_rdata;
                    if (r_j == '0) begin
                        n_state = ST_INS_PUT;
                    end else begin
                        n_j         = r_j - AW'(1);
                        o_mem_raddr = f_phys(r_head, r_j - AW'(1));
                    end
                end else begin
                    o_mem_wdata         = new_entry;
                    n_count             = r_count + CW'(1);
                    n_pe                = r_pe | it_ev;
                    n_hp                = hp_max;
                    o_res_valid         = 1'b1;
                    o_res.kind          = KIND_ACCEPTED;
                    o_res.pending_level = hp_max;
                    o_res.last          = 1'b1;
                    n_state             = ST_IDLE;
                end
            end

            ST_INS_PUT: begin
                // Every held entry moved: the new one becomes the head.
                o_mem_we            = 1'b1;
                o_mem_waddr         = r_head;
                o_mem_wdata         = new_entry;
                n_count             = r_count + CW'(1);
                n_pe                = r_pe | it_ev;
                n_hp                = hp_max;
                o_res_valid         = 1'b1;
                o_res.kind          = KIND_ACCEPTED;
                o_res.pending_level = hp_max;
                o_res.last          = 1'b1;
                n_state             = ST_IDLE;
            end

            ST_REL_HEAD: begin
                // Hold the head and fetch the entry behind it.
                n_cur       = i_mem_rdata;
                o_mem_raddr = f_phys(r_head, AW'(1));
                n_state     = ST_REL_POP;
            end

            ST_REL_POP: begin
                n_count             = pop_count;
                n_head              = pop_head;
                n_hp                = pop_pri;
                n_pe                = r_pe & ~cur_ev;
                o_res_valid         = 1'b1;
                o_res.kind          = KIND_DISPATCH;
                o_res.out_source    = 8'(cur_src);
                o_res.out_priority  = cur_pri;
                o_res.out_events    = 4'(cur_ev);
                o_res.pending_level = pop_pri;
                o_res.last          = !pop_more;
                if (pop_more) begin
                    n_cur       = i_mem_rdata;
                    n_n         = r_n + NW'(1);
                    o_mem_raddr = f_phys(pop_head, AW'(1));
                end else begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
